// ===== rtl/srsb_pkg.sv =====
`default_nettype none

package srsb_pkg;

   localparam int NUM_SETS        = 2048;
   localparam int NUM_WAYS        = 16;
   localparam int SIG_TABLE_DEPTH = 4096;

   localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W = $clog2(NUM_WAYS);
   localparam int SIG_W = $clog2(SIG_TABLE_DEPTH);
   localparam int CLR_N = (NUM_SETS > SIG_TABLE_DEPTH) ? NUM_SETS : SIG_TABLE_DEPTH;
   localparam int CLR_W = $clog2(CLR_N);

   // word fields
   localparam int SET_IDX_W  = 11;
   localparam int WAY_IDX_W  = 4;
   localparam int ADDR_W     = 64;
   localparam int THR_S_W    = 3;
   localparam int THR_R_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [1:0] RRPV_MAX  = 2'd3;
   localparam logic [1:0] RRPV_MRU  = 2'd0;
   localparam logic [1:0] CTR_MAX   = 2'd3;
   localparam logic [1:0] CTR_RESET = 2'd2;

   localparam logic CMD_QUERY  = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_STREAM_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REUSE_THR  = 2'd1;

   localparam logic [THR_S_W-1:0] STREAM_THR_RESET = 3'd3;
   localparam logic [THR_R_W-1:0] REUSE_THR_RESET  = 2'd2;

   typedef struct packed {
      logic [NUM_WAYS-1:0][1:0]       rrpv;
      logic [NUM_WAYS-1:0][SIG_W-1:0] sig;
      logic [NUM_WAYS-1:0]            reused;
      logic [ADDR_W-1:0]              prev_addr;
      logic [ADDR_W-1:0]              prev_delta;
      logic [3:0]                     hist;
   } set_word_type;

   typedef struct packed {
      logic              command;
      logic [SET_W-1:0]  set_idx;
      logic [WAY_W-1:0]  way;
      logic [ADDR_W-1:0] addr;
      logic [SIG_W-1:0]  sig;
      logic              hit;
      logic              evicted;
   } item_type;

   typedef struct packed {
      logic             clr_en;
      logic [SET_W-1:0] clr_addr;
      logic             rd_en;
      logic [SET_W-1:0] rd_addr;
      logic             proc_en;
   } set_ctl_type;

   typedef struct packed {
      logic [WAY_IDX_W-1:0] victim;
      logic                 streaming;
      logic [SIG_W-1:0]     old_sig;
      logic                 old_reused;
   } set_res_type;

   typedef struct packed {
      logic             clr_en;
      logic [SIG_W-1:0] clr_addr;
      logic             rd_en;
      logic [SIG_W-1:0] rd_addr;
      logic             inc_en;
      logic             dec_en;
      logic [SIG_W-1:0] wr_addr;
   } sig_ctl_type;

   function automatic logic [SET_W-1:0] set_of(input logic [SET_IDX_W-1:0] s);
      logic [SET_W+SET_IDX_W-1:0] e;
      e = {{SET_W{1'b0}}, s};
      return e[SET_W-1:0];
   endfunction

   function automatic logic [WAY_W-1:0] way_of(input logic [WAY_IDX_W-1:0] w);
      logic [WAY_W+WAY_IDX_W-1:0] e;
      e = {{WAY_W{1'b0}}, w};
      return e[WAY_W-1:0];
   endfunction

   function automatic logic [SIG_W-1:0] sig_of(input logic [ADDR_W-1:0] pc);
      return pc[2 +: SIG_W];
   endfunction

   function automatic logic [WAY_IDX_W-1:0] victim_of(input logic [WAY_W-1:0] w);
      logic [WAY_W+WAY_IDX_W-1:0] e;
      e = {{WAY_IDX_W{1'b0}}, w};
      return e[WAY_IDX_W-1:0];
   endfunction

   function automatic logic [WAY_W-1:0] first_set(input logic [NUM_WAYS-1:0] v);
      logic [WAY_W-1:0] idx;
      idx = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (v[w]) begin
            idx = WAY_W'(w);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/srsb_req_if.sv =====
`default_nettype none

interface srsb_req_if;
   logic                            valid;
   logic                            ready;
   logic                            command;
   logic [srsb_pkg::SET_IDX_W-1:0]  set_index;
   logic [srsb_pkg::WAY_IDX_W-1:0]  way_index;
   logic [srsb_pkg::ADDR_W-1:0]     phys_addr;
   logic [srsb_pkg::ADDR_W-1:0]     prog_counter;
   logic                            is_hit;
   logic                            evicted_valid;

   modport source (output valid, command, set_index, way_index, phys_addr, prog_counter,
                   is_hit, evicted_valid, input ready);
   modport sink   (input valid, command, set_index, way_index, phys_addr, prog_counter,
                   is_hit, evicted_valid, output ready);
endinterface

`default_nettype wire

// ===== rtl/srsb_rsp_if.sv =====
`default_nettype none

interface srsb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [srsb_pkg::WAY_IDX_W-1:0]  victim_way;
   logic                            set_streaming;

   modport source (output valid, victim_way, set_streaming, input ready);
   modport sink   (input valid, victim_way, set_streaming, output ready);
endinterface

`default_nettype wire

// ===== rtl/srsb_csr_if.sv =====
`default_nettype none

interface srsb_csr_if;
   logic                             valid;
   logic                             ready;
   logic [srsb_pkg::CSR_IDX_W-1:0]   reg_index;
   logic [srsb_pkg::CSR_DATA_W-1:0]  wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ship_rrip_stream_bypass_policy.sv =====
`default_nettype none

// channel   | dir | handshake    | word
// ----------+-----+--------------+------------------------------------------------------
// req_bus   | in  | valid/ready  | command, set_index, way_index, phys_addr, prog_counter,
//           |     |              | is_hit, evicted_valid
// rsp_bus   | out | valid/ready  | victim_way, set_streaming
// csr_bus   | in  | valid/ready  | reg_index, wr_data (0 stream threshold, 1 reuse threshold)
//
// One word at a time: queries and hit updates step through accept, set-memory read then
// modify/write-back, and result load; miss updates add a counter-memory read of the evicted
// block's signature. The registered set-memory read and the single counter port set this.
// After reset a clearing pass over every set and counter entry runs with
// req_bus.ready low; csr writes are always taken.
// A stalled rsp_bus holds the next result in the load state; req_bus stays low meanwhile.

module ship_rrip_stream_bypass_policy (
   input  wire            clock,
   input  wire            reset,
   srsb_req_if.sink       req_bus,
   srsb_rsp_if.source     rsp_bus,
   srsb_csr_if.sink       csr_bus
);
   import srsb_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_DEC   = 5'b01000,
      ST_PUSH  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [CLR_W-1:0]     clr_ff, clr_in;
   item_type             item_ff, item_in;
   logic [WAY_IDX_W-1:0] res_victim_ff, res_victim_in;
   logic                 res_stream_ff, res_stream_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WAY_IDX_W-1:0] rsp_victim_ff, rsp_victim_in;
   logic                 rsp_stream_ff, rsp_stream_in;
   logic [THR_S_W-1:0]   stream_thr_ff, stream_thr_in;
   logic [THR_R_W-1:0]   reuse_thr_ff, reuse_thr_in;

   logic          accept;
   logic          push;
   logic          csr_we;
   logic          is_miss_upd;
   set_ctl_type   set_ctl;
   sig_ctl_type   sig_ctl;
   set_res_type   set_res;
   logic [1:0]    sig_count;

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.victim_way  = rsp_victim_ff;
   assign rsp_bus.set_streaming = rsp_stream_ff;

   assign accept      = req_bus.valid && req_bus.ready;
   assign push        = (state_ff == ST_PUSH) && (!rsp_valid_ff || rsp_bus.ready);
   assign csr_we      = csr_bus.valid && csr_bus.ready;
   assign is_miss_upd = (item_ff.command == CMD_UPDATE) && !item_ff.hit;

   always_comb begin
      set_ctl.clr_en   = (state_ff == ST_CLEAR) &&
                         ({1'b0, clr_ff} < (CLR_W + 1)'(NUM_SETS));
      set_ctl.clr_addr = clr_ff[SET_W-1:0];
      set_ctl.rd_en    = accept;
      set_ctl.rd_addr  = set_of(req_bus.set_index);
      set_ctl.proc_en  = (state_ff == ST_READ);

      sig_ctl.clr_en   = (state_ff == ST_CLEAR) &&
                         ({1'b0, clr_ff} < (CLR_W + 1)'(SIG_TABLE_DEPTH));
      sig_ctl.clr_addr = clr_ff[SIG_W-1:0];
      sig_ctl.rd_en    = accept || ((state_ff == ST_READ) && is_miss_upd);
      sig_ctl.rd_addr  = accept ? sig_of(req_bus.prog_counter) : set_res.old_sig;
      sig_ctl.inc_en   = (state_ff == ST_READ) && (item_ff.command == CMD_UPDATE) &&
                         item_ff.hit;
      sig_ctl.dec_en   = (state_ff == ST_DEC) && item_ff.evicted && !set_res.old_reused;
      sig_ctl.wr_addr  = sig_ctl.dec_en ? set_res.old_sig : item_ff.sig;
   end

   srsb_set_unit u_set (
      .clock      (clock),
      .ctl        (set_ctl),
      .item       (item_ff),
      .sig_count  (sig_count),
      .stream_thr (stream_thr_ff),
      .reuse_thr  (reuse_thr_ff),
      .res        (set_res)
   );

   srsb_sig_unit u_sig (
      .clock (clock),
      .ctl   (sig_ctl),
      .count (sig_count)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      item_in       = item_ff;
      res_victim_in = res_victim_ff;
      res_stream_in = res_stream_ff;
      rsp_victim_in = rsp_victim_ff;
      rsp_stream_in = rsp_stream_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      stream_thr_in = stream_thr_ff;
      reuse_thr_in  = reuse_thr_ff;

      if (csr_we) begin
         case (csr_bus.reg_index)
            REG_STREAM_THR: stream_thr_in = csr_bus.wr_data[THR_S_W-1:0];
            REG_REUSE_THR:  reuse_thr_in  = csr_bus.wr_data[THR_R_W-1:0];
            default:        ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_in.command = req_bus.command;
               item_in.set_idx = set_of(req_bus.set_index);
               item_in.way     = way_of(req_bus.way_index);
               item_in.addr    = req_bus.phys_addr;
               item_in.sig     = sig_of(req_bus.prog_counter);
               item_in.hit     = req_bus.is_hit;
               item_in.evicted = req_bus.evicted_valid;
               state_in        = ST_READ;
            end
         end
         ST_READ: begin
            res_victim_in = set_res.victim;
            res_stream_in = set_res.streaming;
            state_in      = is_miss_upd ? ST_DEC : ST_PUSH;
         end
         ST_DEC: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (push) begin
               rsp_valid_in  = 1'b1;
               rsp_victim_in = res_victim_ff;
               rsp_stream_in = res_stream_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         stream_thr_ff <= STREAM_THR_RESET;
         reuse_thr_ff  <= REUSE_THR_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
         stream_thr_ff <= stream_thr_in;
         reuse_thr_ff  <= reuse_thr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      res_victim_ff <= res_victim_in;
      res_stream_ff <= res_stream_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_stream_ff <= rsp_stream_in;
   end

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_READ))
      else $error("accepted word did not move to set read");

   a_query_no_dec: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) && (item_ff.command == CMD_QUERY)) |=> (state_ff == ST_PUSH))
      else $error("query entered counter decrement");

   a_ctr_one_write: assert property (@(posedge clock) disable iff (reset)
      !(sig_ctl.inc_en && sig_ctl.dec_en))
      else $error("counter increment and decrement together");

   a_push_valid: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_valid_ff)
      else $error("result load lost");

endmodule

`default_nettype wire

// ===== rtl/srsb_set_unit.sv =====
`default_nettype none

module srsb_set_unit (
   input  wire                                clock,
   input  wire srsb_pkg::set_ctl_type         ctl,
   input  wire srsb_pkg::item_type            item,
   input  wire [1:0]                          sig_count,
   input  wire [srsb_pkg::THR_S_W-1:0]        stream_thr,
   input  wire [srsb_pkg::THR_R_W-1:0]        reuse_thr,
   output srsb_pkg::set_res_type              res
);
   import srsb_pkg::*;

   set_word_type set_mem [NUM_SETS];
   set_word_type rd_word_ff;

   set_word_type         new_word;
   set_word_type         clr_word;
   logic [NUM_WAYS-1:0]  is3;
   logic [NUM_WAYS-1:0]  is2;
   logic                 any3;
   logic                 any2;
   logic [ADDR_W-1:0]    delta;
   logic                 match;
   logic [3:0]           hist;
   logic [THR_S_W-1:0]   cnt;
   logic                 streaming;
   logic                 insert_lru;

   always_comb begin
      clr_word            = '0;
      clr_word.rrpv       = {NUM_WAYS{RRPV_MAX}};
   end

   always_ff @(posedge clock) begin
      if (ctl.clr_en) begin
         set_mem[ctl.clr_addr] <= clr_word;
      end else if (ctl.proc_en) begin
         set_mem[item.set_idx] <= new_word;
      end
      if (ctl.rd_en) begin
         rd_word_ff <= set_mem[ctl.rd_addr];
      end
   end

   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         is3[w] = (rd_word_ff.rrpv[w] == RRPV_MAX);
         is2[w] = (rd_word_ff.rrpv[w] == 2'd2);
      end
      any3 = |is3;
      any2 = |is2;

      delta = (rd_word_ff.prev_addr != '0) ? (item.addr - rd_word_ff.prev_addr) : '0;
      match = (delta == rd_word_ff.prev_delta) && (delta != '0);
      hist  = {rd_word_ff.hist[2:0], match};
      cnt   = {2'b00, hist[0]} + {2'b00, hist[1]} + {2'b00, hist[2]} + {2'b00, hist[3]};
      streaming  = (cnt >= stream_thr);
      insert_lru = streaming || (sig_count < reuse_thr);

      new_word       = rd_word_ff;
      res.victim     = '0;
      res.streaming  = 1'b0;
      res.old_sig    = rd_word_ff.sig[item.way];
      res.old_reused = rd_word_ff.reused[item.way];

      case (item.command)
         CMD_QUERY: begin
            if (any3) begin
               res.victim = victim_of(first_set(is3));
            end else begin
               // age the whole set; former RRPV 2 ways now sit at max
               for (int w = 0; w < NUM_WAYS; w++) begin
                  new_word.rrpv[w] = rd_word_ff.rrpv[w] + 2'd1;
               end
               res.victim = any2 ? victim_of(first_set(is2)) : '0;
            end
         end
         CMD_UPDATE: begin
            res.streaming       = streaming;
            new_word.prev_addr  = item.addr;
            new_word.prev_delta = delta;
            new_word.hist       = hist;
            if (item.hit) begin
               new_word.rrpv[item.way]   = RRPV_MRU;
               new_word.reused[item.way] = 1'b1;
            end else begin
               new_word.rrpv[item.way]   = insert_lru ? RRPV_MAX : RRPV_MRU;
               new_word.sig[item.way]    = item.sig;
               new_word.reused[item.way] = 1'b0;
            end
         end
         default: begin
            new_word = rd_word_ff;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/srsb_sig_unit.sv =====
`default_nettype none

module srsb_sig_unit (
   input  wire                         clock,
   input  wire srsb_pkg::sig_ctl_type  ctl,
   output logic [1:0]                  count
);
   import srsb_pkg::*;

   logic [1:0] ctr_mem [SIG_TABLE_DEPTH];
   logic [1:0] rd_q_ff;

   logic       wr_en;
   logic [1:0] wr_val;

   always_comb begin
      wr_en  = ctl.inc_en || (ctl.dec_en && (rd_q_ff != 2'd0));
      wr_val = ctl.inc_en ? ((rd_q_ff == CTR_MAX) ? CTR_MAX : rd_q_ff + 2'd1)
                          : rd_q_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (ctl.clr_en) begin
         ctr_mem[ctl.clr_addr] <= CTR_RESET;
      end else if (wr_en) begin
         ctr_mem[ctl.wr_addr] <= wr_val;
      end
      if (ctl.rd_en) begin
         rd_q_ff <= ctr_mem[ctl.rd_addr];
      end
   end

   assign count = rd_q_ff;

endmodule

`default_nettype wire
